>>> rtl/core/tttb_pkg.sv
// Shared constants and types for the tick-to-millisecond timebase.
package tttb_pkg;

    localparam int DATA_WIDTH         = 32;
    localparam int TICK_WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_WIDTH    = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICK_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_MS = 2'd1;

    localparam logic [DATA_WIDTH-1:0] TICK_PERIOD_RESET  = 32'hFFFF_FFFF;
    localparam logic [DATA_WIDTH-1:0] TICKS_PER_MS_RESET = 32'd1000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/core/tttb_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tttb_divider #(
    parameter int DIVIDEND_WIDTH = tttb_pkg::TICK_WIDTH_DEFAULT,
    parameter int DIVISOR_WIDTH  = tttb_pkg::DATA_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic [DIVIDEND_WIDTH-1:0] quotient,
    output logic [DIVISOR_WIDTH-1:0]  remainder,
    output tttb_pkg::div_stat_t       stat
);

    localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_WIDTH-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_WIDTH-1:0] quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVISOR_WIDTH:0]    trial;
    logic [DIVISOR_WIDTH:0]    trial_sub;
    logic                      qbit;

    // shift in the next dividend bit and try the subtract
    assign trial     = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign qbit      = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(DIVIDEND_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_WIDTH-2:0], qbit};
            rem_next = qbit ? trial_sub[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/core/tick_to_millisecond_timebase.sv
// Tick-to-millisecond timebase: top level with sequencer, state and result register.
//
// Each item carries a sample of a wrapping tick counter, a deadline and a restart
// flag; the block turns the wrap-aware tick difference since the kept reference
// into whole milliseconds, adds them to a 32-bit wrapping count and keeps the
// leftover ticks by moving the reference back. An item passes through setup, the
// bit-serial divider by ticks_per_ms (one quotient bit per cycle) and finish, and
// its result is registered as the block returns to idle to take the next item.
// The tick width is capped at 32. Items that need no division (sample above period,
// restart, stale reference) go from setup straight to finish, skipping the divider.
// A new item is accepted while the previous result waits on the output; it then
// holds in its finish step until that result is taken. Configuration registers:
// 0 tick_period, 1 ticks_per_ms; write them only while the block is idle.
// cfg_ready is always high.
module tick_to_millisecond_timebase #(
    parameter int TICK_WIDTH = tttb_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tttb_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tttb_pkg::DATA_WIDTH-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [tttb_pkg::DATA_WIDTH-1:0]        tick_sample,
    input  logic [tttb_pkg::DATA_WIDTH-1:0]        deadline_ms,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [tttb_pkg::DATA_WIDTH-1:0]        now_ms,
    output logic                                   deadline_passed,
    output logic                                   sample_error
);

    localparam int DW = tttb_pkg::DATA_WIDTH;
    localparam int TW = (TICK_WIDTH > DW) ? DW : TICK_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        K_ERR,
        K_RESTART,
        K_STALE,
        K_NORMAL
    } kind_t;

    state_t  state_reg, state_next;
    kind_t   kind_reg, kind_next;

    logic [DW-1:0] tick_period_reg, ticks_per_ms_reg;
    logic [DW-1:0] elapsed_reg, elapsed_next;
    logic [TW-1:0] ref_reg, ref_next;

    logic [TW-1:0] sample_reg;
    logic [DW-1:0] deadline_reg;
    logic          restart_reg;

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] now_ms_reg, now_ms_next;
    logic          passed_reg, passed_next;
    logic          error_reg, error_next;

    logic [TW-1:0] period;
    logic [TW:0]   wrap_diff;
    logic [TW-1:0] diff;
    logic [DW-1:0] divisor;
    logic          div_start;
    logic [TW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic [TW-1:0] rem_t;
    logic [TW:0]   wrap_next;
    logic [TW-1:0] next_ref;
    logic          slot_free;
    tttb_pkg::div_stat_t div_stat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg  <= tttb_pkg::TICK_PERIOD_RESET;
            ticks_per_ms_reg <= tttb_pkg::TICKS_PER_MS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tttb_pkg::REG_TICK_PERIOD:  tick_period_reg  <= cfg_data;
                tttb_pkg::REG_TICKS_PER_MS: ticks_per_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg   <= tick_sample[TW-1:0];
            deadline_reg <= deadline_ms;
            restart_reg  <= restart;
        end
    end

    assign period    = tick_period_reg[TW-1:0];
    assign wrap_diff = {1'b0, sample_reg} + {1'b0, period} - {1'b0, ref_reg};
    assign diff      = (sample_reg < ref_reg) ? wrap_diff[TW-1:0] : (sample_reg - ref_reg);
    assign divisor   = (ticks_per_ms_reg == '0) ? DW'(1) : ticks_per_ms_reg;
    assign div_start = (state_reg == ST_SETUP) && (kind_next == K_NORMAL);

    tttb_divider #(
        .DIVIDEND_WIDTH (TW),
        .DIVISOR_WIDTH  (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (diff),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    // remainder < the divisor and <= diff, so it fits the tick width
    assign rem_t     = remainder[TW-1:0];
    assign wrap_next = {1'b0, sample_reg} + {1'b0, period} - {1'b0, rem_t};
    assign next_ref  = (sample_reg < rem_t) ? wrap_next[TW-1:0] : (sample_reg - rem_t);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        elapsed_next   = elapsed_reg;
        ref_next       = ref_reg;
        out_valid_next = out_valid_reg && !out_ready;
        now_ms_next    = now_ms_reg;
        passed_next    = passed_reg;
        error_next     = error_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (sample_reg > period)
                    kind_next = K_ERR;
                else if (restart_reg)
                    kind_next = K_RESTART;
                else if (ref_reg > period)
                    kind_next = K_STALE;
                else
                    kind_next = K_NORMAL;
                state_next = (kind_next == K_NORMAL) ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    unique case (kind_reg)
                        K_ERR: ;
                        K_RESTART:
                        begin
                            elapsed_next = '0;
                            ref_next     = sample_reg;
                        end
                        K_STALE:
                            ref_next = sample_reg;
                        K_NORMAL:
                        begin
                            elapsed_next = elapsed_reg + DW'(quotient);
                            ref_next     = next_ref;
                        end
                        default: ;
                    endcase
                    out_valid_next = 1'b1;
                    now_ms_next    = elapsed_next;
                    passed_next    = (elapsed_next > deadline_reg);
                    error_next     = (kind_reg == K_ERR);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= K_NORMAL;
            elapsed_reg   <= '0;
            ref_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            elapsed_reg   <= elapsed_next;
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_ms_reg <= now_ms_next;
        passed_reg <= passed_next;
        error_reg  <= error_next;
    end

    assign out_valid       = out_valid_reg;
    assign now_ms          = now_ms_reg;
    assign deadline_passed = passed_reg;
    assign sample_error    = error_reg;

    // divider only runs while the sequencer waits for it
    a_div_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy)
        else $error("divider busy while accepting an item");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    // a rejected sample leaves the count alone
    a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && kind_reg == K_ERR && slot_free) |=> $stable(elapsed_reg))
        else $error("count changed on a rejected sample");

    a_passed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && passed_reg) |-> (now_ms_reg != '0))
        else $error("deadline passed with zero count");

endmodule

>>> sim/tb_tick_to_millisecond_timebase.sv
// Self-checking testbench for the tick-to-millisecond timebase.

class timebase_scoreboard;
    typedef struct packed {
        logic [31:0] now_ms;
        logic        passed;
        logic        bad_sample;
    } ms_result_t;

    bit [31:0]  period;
    bit [31:0]  per_ms;
    bit [31:0]  elapsed;
    bit [31:0]  ref_tick;
    ms_result_t pending_q[$];
    int         n_fail;
    int         n_checked;
    int         n_rejected;
    int         n_restarts;
    int         n_stale;
    int         n_wraps;

    function new();
        period   = tttb_pkg::TICK_PERIOD_RESET;
        per_ms   = tttb_pkg::TICKS_PER_MS_RESET;
        elapsed  = '0;
        ref_tick = '0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
        n_fail++;
    endtask

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == tttb_pkg::REG_TICK_PERIOD)
            period = data;
        else if (idx == tttb_pkg::REG_TICKS_PER_MS)
            per_ms = data;
    endfunction

    // Advance the timebase by one accepted sample and queue its result.
    function void note_sample(bit [31:0] sample, bit [31:0] deadline, bit restart);
        bit [63:0]  s;
        bit [63:0]  p;
        bit [63:0]  last;
        bit [63:0]  div;
        bit [63:0]  diff;
        bit [63:0]  rem;
        ms_result_t r;
        s    = {32'd0, sample};
        p    = {32'd0, period};
        last = {32'd0, ref_tick};
        div  = (per_ms == 0) ? 64'd1 : {32'd0, per_ms};
        r.bad_sample = 1'b0;
        if (s > p) begin
            r.bad_sample = 1'b1;
            n_rejected++;
        end else if (restart) begin
            elapsed  = '0;
            ref_tick = sample;
            n_restarts++;
        end else if (last > p) begin
            // period was lowered under the kept reference
            ref_tick = sample;
            n_stale++;
        end else begin
            if (s < last) begin
                diff = s + p - last;
                n_wraps++;
            end else begin
                diff = s - last;
            end
            elapsed  = elapsed + 32'(diff / div);
            rem      = diff % div;
            ref_tick = 32'((s < rem) ? s + p - rem : s - rem);
        end
        r.now_ms = elapsed;
        r.passed = (elapsed > deadline);
        pending_q.push_back(r);
    endfunction

    task check_result(logic [31:0] now_ms, logic passed, logic bad_sample);
        ms_result_t w;
        if (pending_q.size() == 0) begin
            report("result with nothing expected", now_ms, '0);
        end else begin
            w = pending_q.pop_front();
            if (now_ms !== w.now_ms)
                report("now_ms", now_ms, w.now_ms);
            if (passed !== w.passed)
                report("deadline_passed", {31'd0, passed}, {31'd0, w.passed});
            if (bad_sample !== w.bad_sample)
                report("sample_error", {31'd0, bad_sample}, {31'd0, w.bad_sample});
        end
        n_checked++;
    endtask
endclass

module tb_tick_to_millisecond_timebase;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 40;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [tttb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0] cfg_data        = '0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [31:0] tick_sample     = '0;
    logic [31:0] deadline_ms     = '0;
    logic        restart         = 1'b0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic [31:0] now_ms;
    logic        deadline_passed;
    logic        sample_error;

    timebase_scoreboard sb = new();
    int          cycles      = 0;
    int          burst_left  = 1;
    bit [31:0]   cur_tick    = '0;
    logic [9:0]  stall_phase = '0;

    tick_to_millisecond_timebase dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     sb.pending_q.size());
            $display("[tick_to_millisecond_timebase] ERROR");
            $finish;
        end
    end

    // Receiver stall pattern: free-flowing, alternating, random, then mostly stalled.
    always @(posedge clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= stall_phase[0];
            2'd2:    out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (stall_phase[3:0] < 4'd3);
        endcase
    end

    // Handshakes are sampled mid-cycle, where every signal is settled.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_sample(tick_sample, deadline_ms, restart);
            if (out_valid && out_ready)
                sb.check_result(now_ms, deadline_passed, sample_error);
        end
    end

    task automatic send_item(bit [31:0] s, bit [31:0] d, bit r);
        bit fire;
        in_valid    <= 1'b1;
        tick_sample <= s;
        deadline_ms <= d;
        restart     <= r;
        do begin
            @(negedge clk);
            fire = in_valid && in_ready;
            @(posedge clk);
        end while (!fire);
    endtask

    task automatic pause_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // One item, with the sender's burst/gap shaping applied afterwards.
    task automatic feed(bit [31:0] s, bit [31:0] d, bit r);
        send_item(s, d, r);
        burst_left--;
        if (burst_left <= 0) begin
            pause_input($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic drain();
        pause_input(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        bit fire;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge clk);
            fire = cfg_valid && cfg_ready;
            @(posedge clk);
        end while (!fire);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(bit [31:0] period, bit [31:0] per_ms);
        drain();
        repeat (SETTLE) @(posedge clk);
        write_reg(tttb_pkg::REG_TICK_PERIOD, period);
        write_reg(tttb_pkg::REG_TICKS_PER_MS, per_ms);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count);
        int        i;
        int        kind;
        bit [31:0] s;
        bit [31:0] d;
        bit        r;
        bit [63:0] step;
        bit [63:0] span;
        for (i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            r    = 1'b0;
            span = {32'd0, sb.period} + 64'd1;
            if (kind < 5 && sb.period != 32'hFFFF_FFFF) begin
                // out of range sample, sometimes with restart set
                s = sb.period + 32'd1 + ($urandom % (~sb.period));
                r = $urandom_range(0, 1);
            end else if (kind < 10) begin
                s = 32'(({32'd0, $urandom}) % span);
                r = 1'b1;
            end else if (kind < 15) begin
                s = $urandom;
            end else begin
                case ($urandom_range(0, 3))
                    0:       step = $urandom_range(0, 50);
                    1:       step = {32'd0, sb.per_ms} * $urandom_range(1, 5)
                                    + $urandom_range(0, 3);
                    2:       step = {32'd0, $urandom};
                    default: step = {32'd0, sb.period} - $urandom_range(0, 2);
                endcase
                s = 32'(({32'd0, cur_tick} + step) % span);
            end
            case ($urandom_range(0, 2))
                0:       d = $urandom;
                1:       d = sb.elapsed + $urandom_range(0, 6) - 32'd3;
                default: d = sb.elapsed;
            endcase
            if (s <= sb.period)
                cur_tick = s;
            if (i == count / 2)
                drain();
            feed(s, d, r);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: period at maximum, 1000 ticks per ms.
        feed(32'd0, 32'd0, 1'b1);
        feed(32'd1000, 32'd0, 1'b0);
        feed(32'd1999, 32'd1, 1'b0);
        feed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        feed(32'd500, 32'd0, 1'b0);
        feed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // Lowered period leaves the reference stale; zero ticks per ms acts as 1.
        set_config(32'd100000, 32'd0);
        feed(32'd5, 32'd0, 1'b0);
        feed(32'd100001, 32'd0, 1'b1);
        feed(32'd100000, 32'd99990, 1'b0);
        feed(32'd3, 32'd0, 1'b0);
        feed(32'hFFFF_FFFF, 32'd0, 1'b0);

        set_config(32'd1, 32'hFFFF_FFFF);
        feed(32'd1, 32'd0, 1'b1);
        feed(32'd0, 32'd0, 1'b0);
        feed(32'd2, 32'd0, 1'b0);
        feed(32'd1, 32'd0, 1'b0);

        // Wrap where the leftover exceeds the sample, so the reference wraps back.
        set_config(32'hFFFF_FFFF, 32'd3);
        feed(32'd10, 32'd0, 1'b1);
        feed(32'd5, 32'd0, 1'b0);
        feed(32'd1, 32'd0, 1'b1);
        feed(32'd0, 32'd0, 1'b0);
        feed(32'd1, 32'd0, 1'b0);

        set_config(32'hFFFF_FFFF, 32'd1);
        run_random(150);
        set_config(32'd1000003, 32'd7);
        run_random(150);
        set_config(32'd1, 32'd1);
        run_random(150);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(150);
        set_config(32'd65535, 32'd0);
        run_random(150);
        set_config($urandom_range(2, 32'h7FFF_FFFF), $urandom_range(1, 5000));
        run_random(150);
        set_config($urandom, $urandom_range(1, 100));
        run_random(150);
        set_config(32'hFFFF_FFFF, 32'd1000);
        run_random(150);

        drain();
        repeat (SETTLE + 10) @(posedge clk);

        $display("checked %0d results over 12 settings; %0d out-of-range samples, %0d restarts",
                 sb.n_checked, sb.n_rejected, sb.n_restarts);
        $display("stale references %0d, counter wraps %0d, mismatches %0d",
                 sb.n_stale, sb.n_wraps, sb.n_fail);
        if (sb.n_fail == 0 && sb.pending_q.size() == 0)
            $display("[tick_to_millisecond_timebase] OK");
        else
            $display("[tick_to_millisecond_timebase] ERROR");
        $finish;
    end

endmodule
